[src/mlqs_pkg.sv]
// Shared constants, types and state codes of the multilevel queue scheduler.
package mlqs_pkg;

   localparam int MAX_PROCS   = 32;
   localparam int BURST_WIDTH = 16;

   localparam int ID_W       = 5;
   localparam int CLASS_W    = 2;
   localparam int IDX_W      = $clog2(MAX_PROCS);
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCS);

   localparam logic [BURST_WIDTH-1:0] QUANTUM_RST = BURST_WIDTH'(10);

   // register index, paddr[2]
   localparam logic REG_QUANTUM = 1'b0;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_RUN = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_RR   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SJF  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_FCFS = 2'd3;

   localparam logic STAT_DONE   = 1'b0;
   localparam logic STAT_REJECT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S2_RD, ST_S2_EV,
      ST_S1_RD, ST_S1_EV,
      ST_SI_RD, ST_SI_EV,
      ST_SJ_RD, ST_SJ_EV,
      ST_SI_WR,
      ST_E2_RD, ST_E2_EV,
      ST_S3_RD, ST_S3_EV,
      ST_DONE
   } state_type;

   // process store entry; the id is the entry's index
   typedef struct packed {
      logic [CLASS_W-1:0]     pclass;
      logic [BURST_WIDTH-1:0] burst;
   } entry_word_type;

   // sort buffer entry
   typedef struct packed {
      logic [ID_W-1:0]        id;
      logic [BURST_WIDTH-1:0] burst;
   } sort_word_type;

   typedef struct packed {
      logic           we;
      logic [IDX_W-1:0] waddr;
      entry_word_type wdata;
      logic [IDX_W-1:0] raddr;
   } ent_port_type;

   typedef struct packed {
      logic          we;
      logic [IDX_W-1:0] waddr;
      sort_word_type wdata;
      logic [IDX_W-1:0] raddr;
   } srt_port_type;

   typedef struct packed {
      logic [BURST_WIDTH-1:0] a;
      logic [BURST_WIDTH-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                   lt;
      logic                   eq;
      logic [BURST_WIDTH-1:0] diff;
   } alu_rsp_type;

endpackage

[src/multilevel_queue_scheduler.sv]
// Top level of the multilevel queue scheduler: CSR, stores, shared ALU, sequencer.
//
// channel   ports                                   transfer when
// -------   -------------------------------------   ------------------------------
// request   start/busy, req_action/class/burst      start high while busy low
// result    rsp_strobe, rsp_proc_id/status/last     rsp_strobe high (one cycle)
// csr       psel/penable/pwrite/paddr/pwdata/...    psel & penable & pwrite & pready
//
// An add leaves busy low; a rejected add shows its result the next cycle. A run
// scans the stored entries and sorts those that go through the sort buffer
// (class 2 plus demoted class 1); each exchange compare takes a read and an
// evaluate state, as the sort buffer has a single read port. Reset is synchronous
// and clears the counters and reloads the quantum; the stores need no clearing
// pass since only entries below the count are read. The receiver cannot stall:
// each result is on the ports for exactly one cycle.
module multilevel_queue_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic [mlqs_pkg::CLASS_W-1:0]         req_priority_class,
   input  logic [mlqs_pkg::BURST_WIDTH-1:0]     req_burst_length,
   // result channel
   output logic                                 rsp_strobe,
   output logic [mlqs_pkg::ID_W-1:0]            rsp_proc_id,
   output logic                                 rsp_status,
   output logic                                 rsp_last,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mlqs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mlqs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mlqs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   logic [mlqs_pkg::BURST_WIDTH-1:0] quantum_ff, quantum_in;
   logic                             csr_write;
   logic                             csr_hit;

   mlqs_pkg::ent_port_type   ent_port;
   mlqs_pkg::entry_word_type ent_rdata;
   mlqs_pkg::srt_port_type   srt_port;
   mlqs_pkg::sort_word_type  srt_rdata;
   mlqs_pkg::alu_req_type    alu_req;
   mlqs_pkg::alu_rsp_type    alu_rsp;

   // CSR: quantum is the only register; the word above it reads as zero
   assign pready    = 1'b1;
   assign csr_hit   = paddr[2] == mlqs_pkg::REG_QUANTUM;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      quantum_in = quantum_ff;
      if (csr_write && csr_hit) begin
         quantum_in = pwdata[mlqs_pkg::BURST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= mlqs_pkg::QUANTUM_RST;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   assign prdata = csr_hit ? mlqs_pkg::CSR_DATA_W'(quantum_ff) : '0;

   // process store, arrival order; the entry index doubles as the process id
   mlqs_ram #(
      .WIDTH ($bits(mlqs_pkg::entry_word_type)),
      .DEPTH (mlqs_pkg::MAX_PROCS)
   ) u_ent_ram (
      .clock (clock),
      .we    (ent_port.we),
      .waddr (ent_port.waddr),
      .wdata (ent_port.wdata),
      .raddr (ent_port.raddr),
      .rdata (ent_rdata)
   );

   // sort buffer: class 2 entries, then demoted class 1 entries, sorted in place
   mlqs_ram #(
      .WIDTH ($bits(mlqs_pkg::sort_word_type)),
      .DEPTH (mlqs_pkg::MAX_PROCS)
   ) u_srt_ram (
      .clock (clock),
      .we    (srt_port.we),
      .waddr (srt_port.waddr),
      .wdata (srt_port.wdata),
      .raddr (srt_port.raddr),
      .rdata (srt_rdata)
   );

   // one compare/subtract unit, shared by the quantum check and the sort compares
   mlqs_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   mlqs_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_priority_class (req_priority_class),
      .req_burst_length   (req_burst_length),
      .quantum            (quantum_ff),
      .ent_port           (ent_port),
      .ent_rdata          (ent_rdata),
      .srt_port           (srt_port),
      .srt_rdata          (srt_rdata),
      .alu_req            (alu_req),
      .alu_rsp            (alu_rsp),
      .rsp_strobe         (rsp_strobe),
      .rsp_proc_id        (rsp_proc_id),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule

[src/mlqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mlqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mlqs_alu.sv]
// Shared compare and subtract unit for quantum checks and sort compares.
module mlqs_alu (
   input  mlqs_pkg::alu_req_type req,
   output mlqs_pkg::alu_rsp_type rsp
);

   always_comb begin
      rsp.lt   = req.a < req.b;
      rsp.eq   = req.a == req.b;
      rsp.diff = req.a - req.b;
   end

endmodule

[src/mlqs_seq.sv]
// Sequencer: store fill on add, scan, exchange sort and emit on run.
module mlqs_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [mlqs_pkg::CLASS_W-1:0]        req_priority_class,
   input  logic [mlqs_pkg::BURST_WIDTH-1:0]    req_burst_length,
   input  logic [mlqs_pkg::BURST_WIDTH-1:0]    quantum,
   output mlqs_pkg::ent_port_type              ent_port,
   input  mlqs_pkg::entry_word_type            ent_rdata,
   output mlqs_pkg::srt_port_type              srt_port,
   input  mlqs_pkg::sort_word_type             srt_rdata,
   output mlqs_pkg::alu_req_type               alu_req,
   input  mlqs_pkg::alu_rsp_type               alu_rsp,
   output logic                                rsp_strobe,
   output logic [mlqs_pkg::ID_W-1:0]           rsp_proc_id,
   output logic                                rsp_status,
   output logic                                rsp_last
);

   mlqs_pkg::state_type state_ff, state_in;

   logic [mlqs_pkg::CNT_W-1:0] count_ff, count_in;
   logic [mlqs_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [mlqs_pkg::CNT_W-1:0] jdx_ff, jdx_in;
   logic [mlqs_pkg::CNT_W-1:0] sn_ff, sn_in;
   logic [mlqs_pkg::CNT_W-1:0] emit_ff, emit_in;
   mlqs_pkg::sort_word_type    cur_ff, cur_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [mlqs_pkg::ID_W-1:0]   rsp_proc_id_ff, rsp_proc_id_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept;
   logic [mlqs_pkg::CNT_W-1:0]  idx_nxt;
   logic [mlqs_pkg::CNT_W-1:0]  jdx_nxt;
   logic [mlqs_pkg::CNT_W-1:0]  emit_nxt;
   logic                        idx_end;
   logic                        emit_req;
   logic [mlqs_pkg::ID_W-1:0]   emit_id;

   assign busy     = state_ff != mlqs_pkg::ST_IDLE;
   assign accept   = start && !busy;
   assign idx_nxt  = idx_ff + 1'b1;
   assign jdx_nxt  = jdx_ff + 1'b1;
   assign emit_nxt = emit_ff + 1'b1;
   assign idx_end  = idx_nxt == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlqs_pkg::ST_IDLE: begin
            if (accept && req_action == mlqs_pkg::ACT_RUN) begin
               state_in = (count_ff == '0) ? mlqs_pkg::ST_DONE : mlqs_pkg::ST_S2_RD;
            end
         end
         mlqs_pkg::ST_S2_RD: state_in = mlqs_pkg::ST_S2_EV;
         mlqs_pkg::ST_S2_EV: state_in = idx_end ? mlqs_pkg::ST_S1_RD : mlqs_pkg::ST_S2_RD;
         mlqs_pkg::ST_S1_RD: state_in = mlqs_pkg::ST_S1_EV;
         mlqs_pkg::ST_S1_EV: begin
            if (!idx_end) begin
               state_in = mlqs_pkg::ST_S1_RD;
            end else begin
               state_in = (sn_in == '0) ? mlqs_pkg::ST_S3_RD : mlqs_pkg::ST_SI_RD;
            end
         end
         mlqs_pkg::ST_SI_RD: state_in = mlqs_pkg::ST_SI_EV;
         mlqs_pkg::ST_SI_EV: begin
            state_in = (idx_nxt == sn_ff) ? mlqs_pkg::ST_E2_RD : mlqs_pkg::ST_SJ_RD;
         end
         mlqs_pkg::ST_SJ_RD: state_in = mlqs_pkg::ST_SJ_EV;
         mlqs_pkg::ST_SJ_EV: begin
            state_in = (jdx_nxt == sn_ff) ? mlqs_pkg::ST_SI_WR : mlqs_pkg::ST_SJ_RD;
         end
         mlqs_pkg::ST_SI_WR: state_in = mlqs_pkg::ST_SI_RD;
         mlqs_pkg::ST_E2_RD: state_in = mlqs_pkg::ST_E2_EV;
         mlqs_pkg::ST_E2_EV: begin
            state_in = (idx_nxt == sn_ff) ? mlqs_pkg::ST_S3_RD : mlqs_pkg::ST_E2_RD;
         end
         mlqs_pkg::ST_S3_RD: state_in = mlqs_pkg::ST_S3_EV;
         mlqs_pkg::ST_S3_EV: state_in = idx_end ? mlqs_pkg::ST_DONE : mlqs_pkg::ST_S3_RD;
         mlqs_pkg::ST_DONE:  state_in = mlqs_pkg::ST_IDLE;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      jdx_in   = jdx_ff;
      sn_in    = sn_ff;
      emit_in  = emit_ff;
      cur_in   = cur_ff;

      ent_port.we          = 1'b0;
      ent_port.waddr       = count_ff[mlqs_pkg::IDX_W-1:0];
      ent_port.wdata.pclass = req_priority_class;
      ent_port.wdata.burst  = req_burst_length;
      ent_port.raddr       = idx_ff[mlqs_pkg::IDX_W-1:0];

      srt_port.we    = 1'b0;
      srt_port.waddr = sn_ff[mlqs_pkg::IDX_W-1:0];
      srt_port.wdata = cur_ff;
      srt_port.raddr = idx_ff[mlqs_pkg::IDX_W-1:0];

      alu_req.a = ent_rdata.burst;
      alu_req.b = quantum;

      emit_req = 1'b0;
      emit_id  = mlqs_pkg::ID_W'(idx_ff);

      rsp_strobe_in  = 1'b0;
      rsp_proc_id_in = rsp_proc_id_ff;
      rsp_status_in  = mlqs_pkg::STAT_DONE;
      rsp_last_in    = 1'b0;

      unique case (state_ff)
         mlqs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == mlqs_pkg::ACT_RUN) begin
                  idx_in  = '0;
                  sn_in   = '0;
                  emit_in = '0;
               end else if (req_priority_class != mlqs_pkg::CLASS_NONE) begin
                  if (count_ff == mlqs_pkg::MAX_CNT) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_proc_id_in = count_ff[mlqs_pkg::ID_W-1:0];
                     rsp_status_in  = mlqs_pkg::STAT_REJECT;
                     rsp_last_in    = 1'b1;
                  end else begin
                     ent_port.we = 1'b1;
                     count_in    = count_ff + 1'b1;
                  end
               end
            end
         end
         mlqs_pkg::ST_S2_EV: begin
            if (ent_rdata.pclass == mlqs_pkg::CLASS_SJF) begin
               srt_port.we          = 1'b1;
               srt_port.wdata.id    = mlqs_pkg::ID_W'(idx_ff);
               srt_port.wdata.burst = ent_rdata.burst;
               sn_in                = sn_ff + 1'b1;
            end
            idx_in = idx_end ? '0 : idx_nxt;
         end
         mlqs_pkg::ST_S1_EV: begin
            if (ent_rdata.pclass == mlqs_pkg::CLASS_RR) begin
               if (alu_rsp.lt || alu_rsp.eq) begin
                  emit_req = 1'b1;
               end else begin
                  // demote with one quantum taken off
                  srt_port.we          = 1'b1;
                  srt_port.wdata.id    = mlqs_pkg::ID_W'(idx_ff);
                  srt_port.wdata.burst = alu_rsp.diff;
                  sn_in                = sn_ff + 1'b1;
               end
            end
            idx_in = idx_end ? '0 : idx_nxt;
         end
         mlqs_pkg::ST_SI_EV: begin
            cur_in = srt_rdata;
            jdx_in = idx_nxt;
            if (idx_nxt == sn_ff) begin
               idx_in = '0;
            end
         end
         mlqs_pkg::ST_SJ_RD: begin
            srt_port.raddr = jdx_ff[mlqs_pkg::IDX_W-1:0];
         end
         mlqs_pkg::ST_SJ_EV: begin
            alu_req.a = srt_rdata.burst;
            alu_req.b = cur_ff.burst;
            if (alu_rsp.lt) begin
               srt_port.we    = 1'b1;
               srt_port.waddr = jdx_ff[mlqs_pkg::IDX_W-1:0];
               cur_in         = srt_rdata;
            end
            jdx_in = jdx_nxt;
         end
         mlqs_pkg::ST_SI_WR: begin
            srt_port.we    = 1'b1;
            srt_port.waddr = idx_ff[mlqs_pkg::IDX_W-1:0];
            idx_in         = idx_nxt;
         end
         mlqs_pkg::ST_E2_EV: begin
            emit_req = 1'b1;
            emit_id  = srt_rdata.id;
            idx_in   = (idx_nxt == sn_ff) ? '0 : idx_nxt;
         end
         mlqs_pkg::ST_S3_EV: begin
            if (ent_rdata.pclass == mlqs_pkg::CLASS_FCFS) begin
               emit_req = 1'b1;
            end
            idx_in = idx_nxt;
         end
         mlqs_pkg::ST_DONE: begin
            count_in = '0;
            sn_in    = '0;
            emit_in  = '0;
         end
         mlqs_pkg::ST_S2_RD, mlqs_pkg::ST_S1_RD, mlqs_pkg::ST_SI_RD,
         mlqs_pkg::ST_E2_RD, mlqs_pkg::ST_S3_RD: begin
         end
      endcase

      // every stored entry completes exactly once per run
      if (emit_req) begin
         rsp_strobe_in  = 1'b1;
         rsp_proc_id_in = emit_id;
         rsp_status_in  = mlqs_pkg::STAT_DONE;
         rsp_last_in    = emit_nxt == count_ff;
         emit_in        = emit_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mlqs_pkg::ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         jdx_ff        <= '0;
         sn_ff         <= '0;
         emit_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         jdx_ff        <= jdx_in;
         sn_ff         <= sn_in;
         emit_ff       <= emit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_proc_id_ff <= rsp_proc_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_proc_id = rsp_proc_id_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mlqs_pkg::MAX_CNT)
      else $error("entry count above store depth");

   a_sort_fill: assert property (@(posedge clock) disable iff (reset)
      sn_ff <= count_ff)
      else $error("sort buffer holds more entries than the store");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= count_ff)
      else $error("more completions than stored entries");

   a_inner_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlqs_pkg::ST_SJ_RD || state_ff == mlqs_pkg::ST_SJ_EV)
      |-> (jdx_ff > idx_ff && jdx_ff < sn_ff))
      else $error("inner sort index out of range");

endmodule
